@@ hw/rtl/gcd_pkg.sv @@
package gcd_pkg;

    // Fixed-point format of angles and trig values
    localparam int FRAC = 30;
    localparam int W    = FRAC + 4;
    localparam int DEF_STAGES = 24;

    // Square root: one result bit per cell, two radicand bits consumed per cell
    localparam int SQ_STEPS = FRAC + 1;
    localparam int NW       = 2 * SQ_STEPS;
    localparam int RW       = SQ_STEPS + 2;

    typedef logic signed [W-1:0] fx_t;

    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452954;
    localparam logic [63:0] DEG_Q60  = (PI_Q60 + 64'd90000000) / 64'd180000000;
    localparam logic [63:0] GAIN_F   = (GAIN_Q62 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    localparam logic [63:0] PI_F     = (PI_Q60 + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    localparam logic [63:0] ONE_F    = 64'd1 << FRAC;

    // atan(2^-i) in Q30, rounded; small angles are just 2^-i
    function automatic logic [63:0] atan_q(input int i);
        logic [63:0] v;
        unique case (i)
            0:  v = (PI_Q60 + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
            1:  v = 64'd497837829;
            2:  v = 64'd263043837;
            3:  v = 64'd133525159;
            4:  v = 64'd67021687;
            5:  v = 64'd33543516;
            6:  v = 64'd16775851;
            7:  v = 64'd8388437;
            8:  v = 64'd4194283;
            9:  v = 64'd2097149;
            10: v = 64'd1048576;
            default: begin
                if (i <= FRAC)
                    v = 64'd1 << (FRAC - i);
                else if (i == FRAC + 1)
                    v = 64'd1;
                else
                    v = 64'd0;
            end
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/gcd_rot_cell.sv @@
// One rotation-mode CORDIC step: drives z towards zero
module gcd_rot_cell import gcd_pkg::*; #(
    parameter int SHIFT = 0,
    parameter int TW    = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  fx_t           x_in,
    input  fx_t           y_in,
    input  fx_t           z_in,
    input  logic [TW-1:0] tag_in,
    output fx_t           x_out,
    output fx_t           y_out,
    output fx_t           z_out,
    output logic [TW-1:0] tag_out
);

    localparam logic [63:0] ATAN64 = atan_q(SHIFT);
    localparam fx_t ATAN = fx_t'(ATAN64[W-1:0]);

    fx_t x_reg, y_reg, z_reg, x_next, y_next, z_next, dx, dy;
    logic [TW-1:0] tag_reg;

    // step direction from the sign of the residual angle
    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!z_in[W-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

@@ hw/rtl/gcd_vec_cell.sv @@
// One vectoring-mode CORDIC step: drives y towards zero, gathers the angle in z
module gcd_vec_cell import gcd_pkg::*; #(
    parameter int SHIFT = 0,
    parameter int TW    = 1
) (
    input  logic          aclk,
    input  logic          en,
    input  fx_t           x_in,
    input  fx_t           y_in,
    input  fx_t           z_in,
    input  logic [TW-1:0] tag_in,
    output fx_t           x_out,
    output fx_t           y_out,
    output fx_t           z_out,
    output logic [TW-1:0] tag_out
);

    localparam logic [63:0] ATAN64 = atan_q(SHIFT);
    localparam fx_t ATAN = fx_t'(ATAN64[W-1:0]);

    fx_t x_reg, y_reg, z_reg, x_next, y_next, z_next, dx, dy;
    logic [TW-1:0] tag_reg;

    // rotate towards the x axis
    always_comb begin
        dx = y_in >>> SHIFT;
        dy = x_in >>> SHIFT;
        if (!y_in[W-1] && (y_in != '0)) begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ATAN;
        end else begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            tag_reg <= tag_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign tag_out = tag_reg;

endmodule

@@ hw/rtl/gcd_sqrt_cell.sv @@
// One restoring square-root step: settles one root bit
module gcd_sqrt_cell import gcd_pkg::*; #(
    parameter int TW = 1
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [RW-1:0]       rem_in,
    input  logic [SQ_STEPS-1:0] root_in,
    input  logic [NW-1:0]       rad_in,
    input  logic [TW-1:0]       tag_in,
    output logic [RW-1:0]       rem_out,
    output logic [SQ_STEPS-1:0] root_out,
    output logic [NW-1:0]       rad_out,
    output logic [TW-1:0]       tag_out
);

    logic [RW+1:0]       rem_ext, trial;
    logic [RW-1:0]       rem_reg, rem_next;
    logic [SQ_STEPS-1:0] root_reg, root_next;
    logic [NW-1:0]       rad_reg;
    logic [TW-1:0]       tag_reg;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        rem_ext = {rem_in, rad_in[NW-1:NW-2]};
        trial   = {1'b0, root_in, 2'b01};
        if (rem_ext >= trial) begin
            rem_next  = RW'(rem_ext - trial);
            root_next = {root_in[SQ_STEPS-2:0], 1'b1};
        end else begin
            rem_next  = rem_ext[RW-1:0];
            root_next = {root_in[SQ_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= {rad_in[NW-3:0], 2'b00};
            tag_reg  <= tag_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign rad_out  = rad_reg;
    assign tag_out  = tag_reg;

endmodule

@@ hw/rtl/great_circle_distance.sv @@
// Great-circle distance by the spherical law of cosines. Each input word carries
// two points in signed microdegrees plus four null flags; each output word gives
// the distance in whole metres, or zero with is_null set. The block takes one
// word per clock while s_tready is high and is fully pipelined, made up of angle
// reduction, two unrolled CORDIC rows (sin/cos and acos), a 31-cell square-root
// row and the multiply stages. A two-word output buffer decouples the sides;
// s_tready drops only while two results are waiting. The radius register is
// written via cfg_wr_en/cfg_wr_data and must only be changed while the pipeline
// is empty.
module great_circle_distance import gcd_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_STAGES
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85], zero pad
    input  logic [119:0] s_tdata,
    // lat_a_null[0], lon_a_null[1], lat_b_null[2], lon_b_null[3]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_m[25:0], zero pad
    output logic [31:0]  m_tdata,
    // is_null[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_wr_en,
    input  logic [23:0]  cfg_wr_data
);

    localparam int S     = CORDIC_STAGES;
    localparam int DEPTH = 56 + 2 * S;
    localparam logic signed [30:0] A360 = 31'sd360000000;
    localparam logic signed [30:0] A180 = 31'sd180000000;
    localparam logic signed [30:0] A90  = 31'sd90000000;
    localparam logic [63:0] HALF = 64'd1 << (FRAC - 1);
    localparam fx_t ONE_FX  = fx_t'(ONE_F[W-1:0]);
    localparam fx_t PI_FX   = fx_t'(PI_F[W-1:0]);
    localparam fx_t GAIN_FX = fx_t'(GAIN_F[W-1:0]);

    logic en, push, pop;
    logic [DEPTH-1:0] vld_reg, nul_reg;
    logic [23:0] radius_reg;

    // radius register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 24'd6378100;
        end else if (cfg_wr_en) begin
            radius_reg <= cfg_wr_data;
        end
    end

    // valid and null shift lines, one slot per pipeline stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nul_reg <= {nul_reg[DEPTH-2:0], |s_tuser};
        end
    end

    // ---------------- angle reduction, lanes: lat_a, lat_b, dlon ----------------
    logic signed [30:0] ang0_reg [3];
    logic signed [30:0] ang1_reg [3];
    logic signed [30:0] ang2_reg [3];
    logic signed [30:0] ang3_reg [3];
    logic [2:0]         negc3_reg, negc4_reg, negc5_reg, negc6_reg, negc7_reg;
    logic [26:0]        mag4_reg [3];
    logic [2:0]         sgn4_reg, sgn5_reg, sgn6_reg;
    logic [61:0]        prod5_reg [3];
    logic [61:0]        prod5_rnd [3];
    logic [31:0]        rnd6_reg [3];
    fx_t                z7_reg [3];
    logic signed [30:0] lat_a_ext, lat_b_ext, dlon;

    assign lat_a_ext = {{3{s_tdata[27]}}, s_tdata[27:0]};
    assign lat_b_ext = {{3{s_tdata[84]}}, s_tdata[84:57]};
    assign dlon = {{2{s_tdata[113]}}, s_tdata[113:85]} - {{2{s_tdata[56]}}, s_tdata[56:28]};

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            prod5_rnd[l] = prod5_reg[l] + HALF[61:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang0_reg[0] <= lat_a_ext;
            ang0_reg[1] <= lat_b_ext;
            ang0_reg[2] <= dlon;
            for (int l = 0; l < 3; l++) begin
                // remainder by a full turn
                if (ang0_reg[l] >= A360)
                    ang1_reg[l] <= ang0_reg[l] - A360;
                else if (ang0_reg[l] <= -A360)
                    ang1_reg[l] <= ang0_reg[l] + A360;
                else
                    ang1_reg[l] <= ang0_reg[l];
                // wrap into a half turn either way
                if (ang1_reg[l] > A180)
                    ang2_reg[l] <= ang1_reg[l] - A360;
                else if (ang1_reg[l] < -A180)
                    ang2_reg[l] <= ang1_reg[l] + A360;
                else
                    ang2_reg[l] <= ang1_reg[l];
                // fold into a quarter turn, remember cosine sign
                if (ang2_reg[l] > A90) begin
                    ang3_reg[l]  <= A180 - ang2_reg[l];
                    negc3_reg[l] <= 1'b1;
                end else if (ang2_reg[l] < -A90) begin
                    ang3_reg[l]  <= -A180 - ang2_reg[l];
                    negc3_reg[l] <= 1'b1;
                end else begin
                    ang3_reg[l]  <= ang2_reg[l];
                    negc3_reg[l] <= 1'b0;
                end
                // magnitude, then to radians
                mag4_reg[l]  <= ang3_reg[l][30] ? 27'(-ang3_reg[l]) : ang3_reg[l][26:0];
                sgn4_reg[l]  <= ang3_reg[l][30];
                prod5_reg[l] <= 62'(mag4_reg[l]) * 62'(DEG_Q60[34:0]);
                rnd6_reg[l]  <= prod5_rnd[l][61:30];
                z7_reg[l]    <= sgn6_reg[l] ? -fx_t'({2'b00, rnd6_reg[l]})
                                            : fx_t'({2'b00, rnd6_reg[l]});
            end
            negc4_reg <= negc3_reg;
            negc5_reg <= negc4_reg;
            negc6_reg <= negc5_reg;
            negc7_reg <= negc6_reg;
            sgn5_reg  <= sgn4_reg;
            sgn6_reg  <= sgn5_reg;
        end
    end

    // ---------------- sin/cos rows ----------------
    fx_t rx [3][S+1];
    fx_t ry [3][S+1];
    fx_t rz [3][S+1];
    logic rtag [3][S+1];

    genvar gl, gk;
    generate
        for (gl = 0; gl < 3; gl++) begin : g_lane
            assign rx[gl][0]   = GAIN_FX;
            assign ry[gl][0]   = '0;
            assign rz[gl][0]   = z7_reg[gl];
            assign rtag[gl][0] = negc7_reg[gl];
            for (gk = 0; gk < S; gk++) begin : g_rot
                gcd_rot_cell #(.SHIFT(gk), .TW(1)) u_cell (
                    .aclk    (aclk),
                    .en      (en),
                    .x_in    (rx[gl][gk]),
                    .y_in    (ry[gl][gk]),
                    .z_in    (rz[gl][gk]),
                    .tag_in  (rtag[gl][gk]),
                    .x_out   (rx[gl][gk+1]),
                    .y_out   (ry[gl][gk+1]),
                    .z_out   (rz[gl][gk+1]),
                    .tag_out (rtag[gl][gk+1])
                );
            end
        end
    endgenerate

    // ---------------- cosine-law sum ----------------
    fx_t sa_reg, sb_reg, ca_reg, cb_reg, cd_reg;
    logic [31:0] asa_reg, asb_reg, aca_reg, acb_reg, acd1_reg, acd2_reg, acd3_reg;
    logic ngss1_reg, ngss2_reg, ngss3_reg, ngss4_reg, ngss5_reg;
    logic ngcc1_reg, ngcc2_reg, ngcc3_reg, sgcd1_reg, sgcd2_reg, sgcd3_reg;
    logic ngccd4_reg, ngccd5_reg;
    logic [63:0] mss_reg, mcc_reg, mccd_reg, mss_rnd, mcc_rnd, mccd_rnd;
    logic [31:0] rss3_reg, rcc3_reg, rss4_reg, rss5_reg, rccd5_reg;
    fx_t pss6_reg, pccd6_reg, sum7_reg, c8_reg;

    assign mss_rnd  = mss_reg + HALF;
    assign mcc_rnd  = mcc_reg + HALF;
    assign mccd_rnd = mccd_reg + HALF;

    always_ff @(posedge aclk) begin
        if (en) begin
            // apply the cosine fold
            sa_reg <= ry[0][S];
            sb_reg <= ry[1][S];
            ca_reg <= rtag[0][S] ? -rx[0][S] : rx[0][S];
            cb_reg <= rtag[1][S] ? -rx[1][S] : rx[1][S];
            cd_reg <= rtag[2][S] ? -rx[2][S] : rx[2][S];
            // sign and magnitude
            asa_reg   <= sa_reg[W-1] ? 32'(-sa_reg) : sa_reg[31:0];
            asb_reg   <= sb_reg[W-1] ? 32'(-sb_reg) : sb_reg[31:0];
            aca_reg   <= ca_reg[W-1] ? 32'(-ca_reg) : ca_reg[31:0];
            acb_reg   <= cb_reg[W-1] ? 32'(-cb_reg) : cb_reg[31:0];
            acd1_reg  <= cd_reg[W-1] ? 32'(-cd_reg) : cd_reg[31:0];
            ngss1_reg <= sa_reg[W-1] ^ sb_reg[W-1];
            ngcc1_reg <= ca_reg[W-1] ^ cb_reg[W-1];
            sgcd1_reg <= cd_reg[W-1];
            // first products
            mss_reg   <= 64'(asa_reg) * 64'(asb_reg);
            mcc_reg   <= 64'(aca_reg) * 64'(acb_reg);
            acd2_reg  <= acd1_reg;
            ngss2_reg <= ngss1_reg;
            ngcc2_reg <= ngcc1_reg;
            sgcd2_reg <= sgcd1_reg;
            // round
            rss3_reg  <= mss_rnd[61:30];
            rcc3_reg  <= mcc_rnd[61:30];
            acd3_reg  <= acd2_reg;
            ngss3_reg <= ngss2_reg;
            ngcc3_reg <= ngcc2_reg;
            sgcd3_reg <= sgcd2_reg;
            // cos a cos b cos dlon
            mccd_reg   <= 64'(rcc3_reg) * 64'(acd3_reg);
            ngccd4_reg <= ngcc3_reg ^ sgcd3_reg;
            rss4_reg   <= rss3_reg;
            ngss4_reg  <= ngss3_reg;
            rccd5_reg  <= mccd_rnd[61:30];
            ngccd5_reg <= ngccd4_reg;
            rss5_reg   <= rss4_reg;
            ngss5_reg  <= ngss4_reg;
            // back to two's complement, add, clamp
            pss6_reg  <= ngss5_reg ? -fx_t'({2'b00, rss5_reg}) : fx_t'({2'b00, rss5_reg});
            pccd6_reg <= ngccd5_reg ? -fx_t'({2'b00, rccd5_reg}) : fx_t'({2'b00, rccd5_reg});
            sum7_reg  <= pss6_reg + pccd6_reg;
            if (sum7_reg > ONE_FX)
                c8_reg <= ONE_FX;
            else if (sum7_reg < -ONE_FX)
                c8_reg <= -ONE_FX;
            else
                c8_reg <= sum7_reg;
        end
    end

    // ---------------- 1 - c^2 ----------------
    logic [FRAC:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, v4_reg;
    logic cs1_reg, cs2_reg, cs3_reg, cs4_reg;
    logic [61:0] csq2_reg, csq_rnd;
    logic [31:0] csq3_reg;
    logic [31:0] one_minus;

    assign csq_rnd   = csq2_reg + HALF[61:0];
    assign one_minus = ONE_F[31:0] - csq3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ac1_reg  <= c8_reg[W-1] ? (FRAC+1)'(-c8_reg) : c8_reg[FRAC:0];
            cs1_reg  <= c8_reg[W-1];
            csq2_reg <= 62'(ac1_reg) * 62'(ac1_reg);
            ac2_reg  <= ac1_reg;
            cs2_reg  <= cs1_reg;
            csq3_reg <= csq_rnd[61:30];
            ac3_reg  <= ac2_reg;
            cs3_reg  <= cs2_reg;
            v4_reg   <= one_minus[FRAC:0];
            ac4_reg  <= ac3_reg;
            cs4_reg  <= cs3_reg;
        end
    end

    // ---------------- square-root row ----------------
    logic [RW-1:0]       sq_rem  [SQ_STEPS+1];
    logic [SQ_STEPS-1:0] sq_root [SQ_STEPS+1];
    logic [NW-1:0]       sq_rad  [SQ_STEPS+1];
    logic [FRAC+1:0]     sq_tag  [SQ_STEPS+1];

    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_rad[0]  = {1'b0, v4_reg, {FRAC{1'b0}}};
    assign sq_tag[0]  = {cs4_reg, ac4_reg};

    generate
        for (gk = 0; gk < SQ_STEPS; gk++) begin : g_sqrt
            gcd_sqrt_cell #(.TW(FRAC + 2)) u_cell (
                .aclk     (aclk),
                .en       (en),
                .rem_in   (sq_rem[gk]),
                .root_in  (sq_root[gk]),
                .rad_in   (sq_rad[gk]),
                .tag_in   (sq_tag[gk]),
                .rem_out  (sq_rem[gk+1]),
                .root_out (sq_root[gk+1]),
                .rad_out  (sq_rad[gk+1]),
                .tag_out  (sq_tag[gk+1])
            );
        end
    endgenerate

    // ---------------- acos row ----------------
    fx_t vx [S+1];
    fx_t vy [S+1];
    fx_t vz [S+1];
    logic vtag [S+1];

    assign vx[0]   = fx_t'({3'b000, sq_tag[SQ_STEPS][FRAC:0]});
    assign vy[0]   = fx_t'({3'b000, sq_root[SQ_STEPS]});
    assign vz[0]   = '0;
    assign vtag[0] = sq_tag[SQ_STEPS][FRAC+1];

    generate
        for (gk = 0; gk < S; gk++) begin : g_vec
            gcd_vec_cell #(.SHIFT(gk), .TW(1)) u_cell (
                .aclk    (aclk),
                .en      (en),
                .x_in    (vx[gk]),
                .y_in    (vy[gk]),
                .z_in    (vz[gk]),
                .tag_in  (vtag[gk]),
                .x_out   (vx[gk+1]),
                .y_out   (vy[gk+1]),
                .z_out   (vz[gk+1]),
                .tag_out (vtag[gk+1])
            );
        end
    endgenerate

    // ---------------- angle to metres ----------------
    fx_t         zz1_reg;
    logic [31:0] zc2_reg;
    logic [55:0] dist3_reg, dist_rnd;
    logic [25:0] dist4_reg;

    assign dist_rnd = dist3_reg + HALF[55:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            zz1_reg   <= vtag[S] ? PI_FX - vz[S] : vz[S];
            zc2_reg   <= zz1_reg[W-1] ? 32'd0 : zz1_reg[31:0];
            dist3_reg <= 56'(zc2_reg) * 56'(radius_reg);
            dist4_reg <= dist_rnd[55:30];
        end
    end

    // ---------------- two-word output buffer ----------------
    logic [26:0] obuf_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg, cnt_next;

    assign en   = (cnt_reg != 2'd2);
    assign push = en && vld_reg[DEPTH-1];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            obuf_reg[wr_ptr_reg] <= nul_reg[DEPTH-1] ? {1'b1, 26'd0} : {1'b0, dist4_reg};
        end
    end

    assign s_tready = en;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {6'd0, obuf_reg[rd_ptr_reg][25:0]};
    assign m_tuser  = obuf_reg[rd_ptr_reg][26];

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_tready)
        else $error("input taken while output buffer full");

    a_null_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[25:0] == 26'd0))
        else $error("null word with nonzero distance");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd1 && pop && !push) |=> !m_tvalid)
        else $error("output valid after last word drained");

endmodule
